FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. Each use expects clk and
// arst_n to be in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

FILE: rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Types, codes and keyword tables of the serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int MAX_BODY_BYTES = 4095;
	localparam int MIN_BODY_BYTES = 5;
	localparam int BODY_LEN_W     = $clog2(MAX_BODY_BYTES + 1);

	localparam int CAT_COUNT = 12;
	localparam int CAT_W     = 4;
	localparam logic [CAT_W-1:0] CAT_UNKNOWN = 4'd12;

	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0A;

	localparam logic [7:0] START_FIRST_RST  = 8'd18;
	localparam logic [7:0] START_SECOND_RST = 8'd52;

	// config register indexes
	localparam logic REG_START_FIRST  = 1'b0;
	localparam logic REG_START_SECOND = 1'b1;

	// keywords, right-justified and zero padded
	localparam logic [63:0] WORD_TEXT [CAT_COUNT] = '{
		64'("txrx"), 64'("bno"), 64'("enc"), 64'("fsr"), 64'("safe"), 64'("ina"),
		64'("ir"), 64'("servo"), 64'("lox"), 64'("ready"), 64'("wifi"),
		64'("shutdown")
	};
	localparam logic [3:0] WORD_LEN [CAT_COUNT] = '{
		4'd4, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3, 4'd2, 4'd5, 4'd3, 4'd5, 4'd4, 4'd8
	};

	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_START,
		MODE_NUMBER,
		MODE_CATEGORY
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_CKSUM_BAD   = 3'd2,
		ST_CAT_MISSING = 3'd3,
		ST_NUMBER_BAD  = 3'd4
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [31:0]           number;
		logic                  mismatch;
		logic [CAT_W-1:0]      code;
		logic [BODY_LEN_W-1:0] length;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// {ok, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (is_digit(c))
			r = {1'b1, c[3:0]};
		else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)))
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

	// drop keywords that do not have character c at position pos
	function automatic logic [CAT_COUNT-1:0] cat_keep(
		input logic [CAT_COUNT-1:0] mask,
		input logic [3:0]           pos,
		input logic [7:0]           c
	);
		logic [63:0]          w;
		logic [CAT_COUNT-1:0] m;
		m = mask;
		for (int i = 0; i < CAT_COUNT; i++) begin
			w = WORD_TEXT[i] << (8 * (8 - int'(WORD_LEN[i])));
			if ((pos >= WORD_LEN[i]) || (w[8 * (7 - int'(pos[2:0])) +: 8] != c))
				m[i] = 1'b0;
		end
		return m;
	endfunction

	// lowest keyword still matching with full length wins
	function automatic logic [CAT_W-1:0] cat_lookup(
		input logic [CAT_COUNT-1:0] mask,
		input logic [3:0]           pos
	);
		logic [CAT_W-1:0] code;
		code = CAT_UNKNOWN;
		for (int i = CAT_COUNT - 1; i >= 0; i--) begin
			if (mask[i] && (pos == WORD_LEN[i]))
				code = CAT_W'(i);
		end
		return code;
	endfunction

endpackage

FILE: rtl/core/serial_packet_deframer.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Start-pair framed ASCII packet receiver with additive hex checksum check.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle; in_stall rises only while the
//   output register and its skid entry both hold results.
// Result path: a frame result passes from the newline transfer through the
//   input register, then the result register (or its skid entry while the
//   output stalls) before it can transfer out.
// Reset: arst_n clears all frame state and the expected count; start bytes
//   return to 0x12 and 0x34. No clearing pass.
`include "assert_macros.svh"

module serial_packet_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	// frame result
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     frame_status,
	output logic [31:0]                    packet_number,
	output logic                           sequence_mismatch,
	output logic [spd_pkg::CAT_W-1:0]      category_code,
	output logic [spd_pkg::BODY_LEN_W-1:0] body_length,
	// config writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [7:0]                     cfg_data
);

	logic [7:0]       start_first_q, start_second_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             res_valid;
	spd_pkg::result_t res;
	spd_pkg::result_t out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic             out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= spd_pkg::START_FIRST_RST;
			start_second_q <= spd_pkg::START_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spd_pkg::REG_START_FIRST:  start_first_q  <= cfg_data;
				spd_pkg::REG_START_SECOND: start_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register; a byte moves on unless the skid entry is occupied
	assign advance  = valid_s1 && !skid_valid_q;
	assign in_stall = valid_s1 && skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	spd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.byte_in      (byte_s1),
		.start_first  (start_first_q),
		.start_second (start_second_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	// result register with one skid entry behind it
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (res_valid)
				out_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign frame_status      = out_q.status;
	assign packet_number     = out_q.number;
	assign sequence_mismatch = out_q.mismatch;
	assign category_code     = out_q.code;
	assign body_length       = out_q.length;

	`ASSERT_CLK(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
	`ASSERT_CLK(a_error_fields_clear, out_valid_q && (out_q.status == spd_pkg::ST_TOO_SHORT || out_q.status == spd_pkg::ST_CKSUM_BAD || out_q.status == spd_pkg::ST_NUMBER_BAD) |-> out_q.number == 32'd0 && !out_q.mismatch && out_q.code == spd_pkg::CAT_UNKNOWN, "error frame carries number or category")
	`ASSERT_NEVER(a_missing_has_code, out_valid_q && out_q.status == spd_pkg::ST_CAT_MISSING && out_q.code != spd_pkg::CAT_UNKNOWN, "category missing with known code")
	`ASSERT_CLK(a_short_length, out_valid_q && out_q.status != spd_pkg::ST_TOO_SHORT |-> out_q.length >= spd_pkg::BODY_LEN_W'(spd_pkg::MIN_BODY_BYTES), "short body not flagged")

endmodule

FILE: rtl/core/spd_parser.sv
// ----------------------------------------------------------------------------
// spd_parser
// Frame state of the deframer: start-pair hunt, streamed body parse with a
// two-byte checksum hold-back, and the end-of-frame result.
// ----------------------------------------------------------------------------
module spd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	input  logic [7:0]            start_first,
	input  logic [7:0]            start_second,
	output logic                  res_valid,
	output spd_pkg::result_t      res
);

	spd_pkg::mode_t                      mode_q, mode_d;
	logic [7:0]                          sum_q, sum_d;
	logic [15:0]                         held_q, held_d;
	logic [spd_pkg::BODY_LEN_W-1:0]      count_q, count_d;
	logic [31:0]                         acc_q, acc_d;
	logic [3:0]                          pos_q, pos_d;
	logic [spd_pkg::CAT_COUNT-1:0]       mask_q, mask_d;
	logic [31:0]                         expected_q, expected_d;
	logic                                bad_q, bad_d;
	logic                                cat_done_q, cat_done_d;

	logic [7:0]  old_byte;
	logic [7:0]  hi, lo;
	logic [4:0]  hi_hex, lo_hex;
	logic [31:0] num_full;
	logic        num_bad;
	logic [3:0]  pos_inc;

	assign old_byte = held_q[15:8];
	assign hi       = held_q[15:8];
	assign lo       = held_q[7:0];
	assign hi_hex   = spd_pkg::hex_nibble(hi);
	assign lo_hex   = spd_pkg::hex_nibble(lo);
	assign pos_inc  = (pos_q == 4'hF) ? pos_q : pos_q + 4'd1;

	// number still open at the newline takes both checksum characters as digits
	assign num_full = (acc_q << 6) + (acc_q << 5) + (acc_q << 2)
		+ 32'({hi[3:0], 3'b000}) + 32'({hi[3:0], 1'b0}) + 32'(lo[3:0]);
	assign num_bad  = bad_q
		|| ((mode_q == spd_pkg::MODE_NUMBER) && (!spd_pkg::is_digit(hi)
		|| !spd_pkg::is_digit(lo)));

	always_comb begin
		mode_d     = mode_q;
		sum_d      = sum_q;
		held_d     = held_q;
		count_d    = count_q;
		acc_d      = acc_q;
		pos_d      = pos_q;
		mask_d     = mask_q;
		expected_d = expected_q;
		bad_d      = bad_q;
		cat_done_d = cat_done_q;
		res_valid  = 1'b0;
		res        = '{status: spd_pkg::ST_OK, number: 32'd0, mismatch: 1'b0,
			code: spd_pkg::CAT_UNKNOWN, length: count_q};

		if (step) begin
			case (mode_q)
				spd_pkg::MODE_HUNT: begin
					if (byte_in == start_first)
						mode_d = spd_pkg::MODE_START;
				end
				spd_pkg::MODE_START: begin
					mode_d = (byte_in == start_second) ? spd_pkg::MODE_NUMBER
						: spd_pkg::MODE_HUNT;
					sum_d      = 8'd0;
					held_d     = 16'd0;
					count_d    = '0;
					acc_d      = 32'd0;
					pos_d      = 4'd0;
					mask_d     = '1;
					bad_d      = 1'b0;
					cat_done_d = 1'b0;
				end
				default: begin
					if (byte_in == spd_pkg::CHAR_LF) begin
						res_valid  = 1'b1;
						expected_d = expected_q + 32'd1;
						if (count_q < spd_pkg::BODY_LEN_W'(spd_pkg::MIN_BODY_BYTES)) begin
							res.status = spd_pkg::ST_TOO_SHORT;
						end else if (!hi_hex[4] || !lo_hex[4]
							|| ({hi_hex[3:0], lo_hex[3:0]} != sum_q)) begin
							res.status = spd_pkg::ST_CKSUM_BAD;
						end else if (num_bad) begin
							res.status = spd_pkg::ST_NUMBER_BAD;
						end else begin
							res.number = (mode_q == spd_pkg::MODE_NUMBER) ? num_full : acc_q;
							res.mismatch = (res.number != expected_q);
							expected_d   = res.number + 32'd1;
							if (mode_q == spd_pkg::MODE_NUMBER)
								res.status = spd_pkg::ST_CAT_MISSING;
							else
								res.code = spd_pkg::cat_lookup(mask_q, pos_q);
						end
						mode_d     = spd_pkg::MODE_HUNT;
						sum_d      = 8'd0;
						held_d     = 16'd0;
						count_d    = '0;
						acc_d      = 32'd0;
						pos_d      = 4'd0;
						mask_d     = '1;
						bad_d      = 1'b0;
						cat_done_d = 1'b0;
					end else begin
						// oldest held byte is now known not to be checksum
						if (count_q >= spd_pkg::BODY_LEN_W'(2)) begin
							sum_d = sum_q + old_byte;
							if (mode_q == spd_pkg::MODE_NUMBER) begin
								if (old_byte == spd_pkg::CHAR_TAB) begin
									if (pos_q == 4'd0)
										bad_d = 1'b1;
									mode_d = spd_pkg::MODE_CATEGORY;
									pos_d  = 4'd0;
								end else if (spd_pkg::is_digit(old_byte)) begin
									acc_d = (acc_q << 3) + (acc_q << 1) + 32'(old_byte[3:0]);
									pos_d = pos_inc;
								end else begin
									bad_d = 1'b1;
								end
							end else if (!cat_done_q) begin
								if (old_byte == spd_pkg::CHAR_TAB) begin
									cat_done_d = 1'b1;
								end else begin
									mask_d = spd_pkg::cat_keep(mask_q, pos_q, old_byte);
									pos_d  = pos_inc;
								end
							end
						end
						held_d = {held_q[7:0], byte_in};
						if (count_q < spd_pkg::BODY_LEN_W'(spd_pkg::MAX_BODY_BYTES))
							count_d = count_q + 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= spd_pkg::MODE_HUNT;
			sum_q      <= 8'd0;
			held_q     <= 16'd0;
			count_q    <= '0;
			acc_q      <= 32'd0;
			pos_q      <= 4'd0;
			mask_q     <= '1;
			expected_q <= 32'd0;
			bad_q      <= 1'b0;
			cat_done_q <= 1'b0;
		end else begin
			mode_q     <= mode_d;
			sum_q      <= sum_d;
			held_q     <= held_d;
			count_q    <= count_d;
			acc_q      <= acc_d;
			pos_q      <= pos_d;
			mask_q     <= mask_d;
			expected_q <= expected_d;
			bad_q      <= bad_d;
			cat_done_q <= cat_done_d;
		end
	end

endmodule
